@@ rtl/core/slb_pkg.sv @@
// Shared types, constants and helper functions for the source byte lexer.
`default_nettype none
package slb_pkg;

  localparam int POS_BITS   = 32;
  localparam int MAX_RES    = 3;
  localparam int DATA_BITS  = 144;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_IDEN    = 3'd1,
    MODE_INT     = 3'd2,
    MODE_COMMENT = 3'd3,
    MODE_EQ      = 3'd4,
    MODE_SKIP    = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    KIND_IDEN    = 4'd0,
    KIND_INT     = 4'd1,
    KIND_DEF     = 4'd2,
    KIND_LPAR    = 4'd3,
    KIND_RPAR    = 4'd4,
    KIND_ARROW   = 4'd5,
    KIND_COLON   = 4'd6,
    KIND_ASSIGN  = 4'd7,
    KIND_SEMI    = 4'd8,
    KIND_COMMA   = 4'd9,
    KIND_SYSCALL = 4'd10,
    KIND_BAD     = 4'd11,
    KIND_END     = 4'd12
  } kind_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic [31:0] col;
    logic [7:0]  bad;
  } res_t;

  // All results caused by one source byte
  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MAX_RES-1:0]      r;
  } bundle_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic pos_t sat_inc(pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic logic [31:0] clip32(pos_t v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'h0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
    return w[31:0];
  endfunction

  // "def"
  function automatic logic [7:0] kw_short_char(logic [1:0] i);
    logic [7:0] ch;
    case (i)
      2'd0:    ch = 8'h64;
      2'd1:    ch = 8'h65;
      2'd2:    ch = 8'h66;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "__syscall__"
  function automatic logic [7:0] kw_long_char(logic [3:0] i);
    logic [7:0] ch;
    case (i)
      4'd0, 4'd1, 4'd9, 4'd10: ch = CH_UNDER;
      4'd2, 4'd4:              ch = 8'h73;
      4'd3:                    ch = 8'h79;
      4'd5:                    ch = 8'h63;
      4'd6:                    ch = 8'h61;
      4'd7, 4'd8:              ch = 8'h6C;
      default:                 ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic mode_pending(mode_t m);
    return m == MODE_IDEN || m == MODE_INT || m == MODE_EQ;
  endfunction

  function automatic res_t make_res(kind_t k, pos_t start, pos_t len, pos_t line,
                                    pos_t col, logic [7:0] bad);
    res_t r;
    r.kind  = k;
    r.start = clip32(start);
    r.len   = clip32(len);
    r.line  = clip32(line);
    r.col   = clip32(col);
    r.bad   = bad;
    return r;
  endfunction

  // Result for a pending identifier, integer or lone '='
  function automatic res_t flush_res(mode_t m, pos_t start, pos_t len, pos_t line,
                                     pos_t col, logic [1:0] kw);
    kind_t k;
    pos_t  l;
    k = KIND_IDEN;
    l = len;
    if (m == MODE_INT) begin
      k = KIND_INT;
    end else if (m == MODE_EQ) begin
      k = KIND_ASSIGN;
      l = pos_t'(1);
    end else if (kw[1] && len == pos_t'(11)) begin
      k = KIND_SYSCALL;
    end else if (kw[0] && len == pos_t'(3)) begin
      k = KIND_DEF;
    end
    return make_res(k, start, l, line, col, 8'h00);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/slb_front.sv @@
// Front end: lexer state, byte classification and result bundling per byte.
`default_nettype none
module slb_front
  import slb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] src_byte,
  input  wire logic       fin,
  output logic            push,
  output bundle_t         bundle
);

  mode_t      mode_r, mode_nxt;
  pos_t       off_r, off_nxt;
  pos_t       line_r, line_nxt;
  pos_t       col_r, col_nxt;
  pos_t       pstart_r, pstart_nxt;
  pos_t       plen_r, plen_nxt;
  pos_t       pline_r, pline_nxt;
  pos_t       pcol_r, pcol_nxt;
  logic [1:0] kw_r, kw_nxt;

  logic [3:0] slot_v;
  res_t       slot [4];
  logic       fall;
  logic [1:0] kw_app;
  logic [1:0] cnt;

  always_comb begin
    kw_app = kw_r;
    if (!(plen_r < pos_t'(3) && src_byte == kw_short_char(plen_r[1:0]))) kw_app[0] = 1'b0;
    if (!(plen_r < pos_t'(11) && src_byte == kw_long_char(plen_r[3:0]))) kw_app[1] = 1'b0;
  end

  always_comb begin
    mode_nxt   = mode_r;
    pstart_nxt = pstart_r;
    plen_nxt   = plen_r;
    pline_nxt  = pline_r;
    pcol_nxt   = pcol_r;
    kw_nxt     = kw_r;
    slot_v     = '0;
    fall       = 1'b0;
    for (int i = 0; i < 4; i++) slot[i] = '0;

    if (mode_r != MODE_SKIP) begin
      if (src_byte == 8'h00) begin
        if (mode_pending(mode_r)) begin
          slot_v[0] = 1'b1;
          slot[0]   = flush_res(mode_r, pstart_r, plen_r, pline_r, pcol_r, kw_r);
        end
        mode_nxt = MODE_SKIP;
      end else begin
        unique case (mode_r)
          MODE_NORMAL: fall = 1'b1;
          MODE_IDEN, MODE_INT: begin
            if (is_digit(src_byte) || (mode_r == MODE_IDEN && is_alpha(src_byte))) begin
              plen_nxt = sat_inc(plen_r);
              kw_nxt   = kw_app;
            end else begin
              slot_v[0] = 1'b1;
              slot[0]   = flush_res(mode_r, pstart_r, plen_r, pline_r, pcol_r, kw_r);
              fall      = 1'b1;
            end
          end
          MODE_EQ: begin
            slot_v[0] = 1'b1;
            if (src_byte == CH_GT) begin
              slot[0]  = make_res(KIND_ARROW, pstart_r, pos_t'(2), pline_r, pcol_r, 8'h00);
              mode_nxt = MODE_NORMAL;
            end else begin
              slot[0] = flush_res(mode_r, pstart_r, plen_r, pline_r, pcol_r, kw_r);
              fall    = 1'b1;
            end
          end
          MODE_COMMENT: if (src_byte == CH_NL) mode_nxt = MODE_NORMAL;
          default: ;
        endcase

        if (fall) begin
          mode_nxt = MODE_NORMAL;
          if (is_alpha(src_byte) || is_digit(src_byte) || src_byte == CH_EQ) begin
            mode_nxt   = is_alpha(src_byte) ? MODE_IDEN :
                         (is_digit(src_byte) ? MODE_INT : MODE_EQ);
            pstart_nxt = off_r;
            plen_nxt   = pos_t'(1);
            pline_nxt  = line_r;
            pcol_nxt   = col_r;
            kw_nxt     = {src_byte == kw_long_char(4'd0), src_byte == kw_short_char(2'd0)};
          end else if (src_byte == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else if (src_byte != CH_SPACE && src_byte != CH_TAB && src_byte != CH_NL) begin
            slot_v[1] = 1'b1;
            case (src_byte)
              CH_LPAR:  slot[1] = make_res(KIND_LPAR, off_r, pos_t'(1), line_r, col_r, 8'h00);
              CH_RPAR:  slot[1] = make_res(KIND_RPAR, off_r, pos_t'(1), line_r, col_r, 8'h00);
              CH_COMMA: slot[1] = make_res(KIND_COMMA, off_r, pos_t'(1), line_r, col_r, 8'h00);
              CH_SEMI:  slot[1] = make_res(KIND_SEMI, off_r, pos_t'(1), line_r, col_r, 8'h00);
              CH_COLON: slot[1] = make_res(KIND_COLON, off_r, pos_t'(1), line_r, col_r, 8'h00);
              default: begin
                slot[1]  = make_res(KIND_BAD, off_r, pos_t'(1), line_r, col_r, src_byte);
                mode_nxt = MODE_SKIP;
              end
            endcase
          end
        end

        if (fin && mode_pending(mode_nxt)) begin
          slot_v[2] = 1'b1;
          slot[2]   = flush_res(mode_nxt, pstart_nxt, plen_nxt, pline_nxt, pcol_nxt, kw_nxt);
        end
      end
    end

    off_nxt = sat_inc(off_r);
    if (src_byte == CH_NL) begin
      line_nxt = sat_inc(line_r);
      col_nxt  = pos_t'(1);
    end else begin
      line_nxt = line_r;
      col_nxt  = sat_inc(col_r);
    end

    if (fin) begin
      slot_v[3]  = 1'b1;
      slot[3]    = make_res(KIND_END, off_nxt, pos_t'(0), line_nxt, col_nxt, 8'h00);
      mode_nxt   = MODE_NORMAL;
      off_nxt    = '0;
      line_nxt   = pos_t'(1);
      col_nxt    = pos_t'(1);
      pstart_nxt = '0;
      plen_nxt   = '0;
      pline_nxt  = pos_t'(1);
      pcol_nxt   = pos_t'(1);
      kw_nxt     = 2'b11;
    end
  end

  // Pack the valid slots in order, keeping at most three
  always_comb begin
    bundle = '0;
    cnt    = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (slot_v[i] && cnt != 2'd3) begin
        bundle.r[cnt] = slot[i];
        cnt           = cnt + 2'd1;
      end
    end
    bundle.cnt = cnt;
    push       = accept && (cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NORMAL;
      off_r    <= '0;
      line_r   <= pos_t'(1);
      col_r    <= pos_t'(1);
      pstart_r <= '0;
      plen_r   <= '0;
      pline_r  <= pos_t'(1);
      pcol_r   <= pos_t'(1);
      kw_r     <= 2'b11;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      off_r    <= off_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      pstart_r <= pstart_nxt;
      plen_r   <= plen_nxt;
      pline_r  <= pline_nxt;
      pcol_r   <= pcol_nxt;
      kw_r     <= kw_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/slb_queue.sv @@
// Two-entry queue of result bundles between front and back ends.
`default_nettype none
module slb_queue
  import slb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  bundle_t   push_data,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output bundle_t   head
);

  bundle_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/slb_back.sv @@
// Back end: walks each bundle and presents one result per transfer.
`default_nettype none
module slb_back
  import slb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             head_valid,
  input  bundle_t               head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [DATA_BITS-1:0]  out_tdata,
  output logic                  out_tlast
);

  logic       valid_r, valid_nxt;
  res_t       data_r;
  logic       last_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       at_end;

  assign load   = head_valid && (!valid_r || out_tready);
  assign at_end = (idx_r == head.cnt - 2'd1);
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (out_tready) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_end ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= head.r[idx_r];
      last_r <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {4'b0000, data_r.bad, data_r.col, data_r.line, data_r.len,
                       data_r.start, data_r.kind};

endmodule
`default_nettype wire

@@ rtl/core/source_byte_lexer.sv @@
// Top level of the source byte lexer: front end, bundle queue, back end.
//
// Source bytes arrive on the in_ stream, one byte per transfer, with in_tlast
// marking the final byte of a source. Tokens leave on the out_ stream, one
// result per transfer; out_tlast marks the last result caused by one byte.
// A byte causes zero to three results (pending token, new token or error,
// end-of-source marker).
// Each byte's bundle is queued, then its results are registered one by one.
// Throughput: one byte per cycle while bytes give at most one result each and
// the receiver is ready; the output register delivers one result per cycle
// while out_tready is high. A two-bundle queue sits between the
// classifier and the output, so input keeps flowing while a result waits.
// in_tready drops only when both queue entries are occupied.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the lexer to line 1, column 1, offset 0. A stalled receiver simply
// holds out_tvalid and data until taken; the queue then fills and throttles
// the input side.
`default_nettype none
module source_byte_lexer
  import slb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] source_byte
  input  wire logic                 in_tlast,   // final_byte
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [3:0] result_kind, [35:4] start_offset, [67:36] token_length,
  // [99:68] line_number, [131:100] column_number, [139:132] bad_byte, rest zero
  output logic [DATA_BITS-1:0]      out_tdata,
  output logic                      out_tlast   // run_last
);

  logic    accept;
  logic    push;
  logic    full;
  logic    pop;
  logic    head_valid;
  bundle_t push_data;
  bundle_t head;

  assign in_tready = !full;
  assign accept    = in_tvalid && !full;

  slb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .src_byte (in_tdata),
    .fin      (in_tlast),
    .push     (push),
    .bundle   (push_data)
  );

  slb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  slb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
